// ===== hdl/poly1305_mac_engine_unit_defines.svh =====
// Assertion macros used by the Poly1305 block engine (p1305_back).
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef POLY1305_MAC_ENGINE_UNIT_DEFINES_SVH
`define POLY1305_MAC_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define P1305_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p1305 assertion failed");
`define P1305_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p1305 assertion failed");
`else
`define P1305_ASSERT(lbl, ante, cons)
`define P1305_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/p1305_pkg.sv =====
// Types and constants for the Poly1305 engine.
// No dependencies.
package p1305_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } out_item_t;

  typedef struct packed {
    logic [127:0] words;
    logic         hibit;
    logic         fold;
    logic         fin;
  } job_t;

  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;

  localparam logic [1:0] CFG_R_LOW    = 2'd0;
  localparam logic [1:0] CFG_R_HIGH   = 2'd1;
  localparam logic [1:0] CFG_PAD_LOW  = 2'd2;
  localparam logic [1:0] CFG_PAD_HIGH = 2'd3;

  localparam logic [31:0] CLAMP_LOW  = 32'h0fffffff;
  localparam logic [31:0] CLAMP_REST = 32'h0ffffffc;

  localparam logic [159:0] NEG_P = {32'hfffffffc, 32'h0, 32'h0, 32'h0, 32'h5};

  localparam logic [4:0] BLOCK_BYTES = 5'd16;

endpackage

// ===== hdl/p1305_fifo.sv =====
// Short job queue between the byte packer and the block engine.
// Uses p1305_pkg::job_t.
module p1305_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  p1305_pkg::job_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output p1305_pkg::job_t pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  p1305_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/p1305_front.sv =====
// Byte packer: builds 16-byte blocks and issues fold and finish jobs.
// Uses p1305_pkg types; feeds p1305_fifo.
module p1305_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  p1305_pkg::in_item_t in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output p1305_pkg::job_t     job_data
);
  logic [127:0] block_r;
  logic [4:0]   cnt_r;
  logic         full;
  logic         acc;
  logic [127:0] pad_one;

  assign in_ready  = job_ready;
  assign acc       = in_valid && in_ready;
  assign full      = (cnt_r == p1305_pkg::BLOCK_BYTES);
  assign job_valid = in_valid && (in_data.kind == p1305_pkg::KIND_FINISH || full);

  always_comb begin
    pad_one = block_r;
    pad_one[{cnt_r[3:0], 3'b000} +: 8] = 8'h01;
    job_data.fin   = (in_data.kind == p1305_pkg::KIND_FINISH);
    job_data.fold  = (cnt_r != '0);
    job_data.hibit = full;
    job_data.words = full ? block_r : pad_one;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_r <= '0;
      cnt_r   <= '0;
    end else if (acc) begin
      if (in_data.kind == p1305_pkg::KIND_FINISH) begin
        block_r <= '0;
        cnt_r   <= '0;
      end else if (full) begin
        block_r <= {120'b0, in_data.data_byte};
        cnt_r   <= 5'd1;
      end else begin
        block_r[{cnt_r[3:0], 3'b000} +: 8] <= in_data.data_byte;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end
endmodule

// ===== hdl/p1305_back.sv =====
// Block engine: multiply by r mod 2^130-5 one product a cycle, reduce, add pad.
// Uses p1305_pkg types and the assertion macros header.
`include "poly1305_mac_engine_unit_defines.svh"
module p1305_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  p1305_pkg::job_t      job_data,
  input  logic [127:0]         r_key,
  input  logic [127:0]         pad,
  output logic                 out_valid,
  input  logic                 out_ready,
  output p1305_pkg::out_item_t out_data
);
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_CARRY  = 6'b001000,
    ST_REDUCE = 6'b010000,
    ST_PAD    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] acc_r [5];
  logic [32:0] a_r [5];
  logic [63:0] p_r [5];
  logic [63:0] prod_r, carry_r;
  logic        pv_r, fin_r;
  logic [2:0]  pn_r, n_r, m_r, k_r;
  logic        out_valid_r;
  p1305_pkg::out_item_t out_data_r;

  logic [31:0]  k [4];
  logic [28:0]  f [4];
  logic [1:0]   d;
  logic [28:0]  coef;
  logic [63:0]  top, base, ta, tb, sum;
  logic [159:0] h, hd;
  logic [127:0] tag;
  logic         out_free, last_issue;

  assign k[0] = r_key[31:0]   & p1305_pkg::CLAMP_LOW;
  assign k[1] = r_key[63:32]  & p1305_pkg::CLAMP_REST;
  assign k[2] = r_key[95:64]  & p1305_pkg::CLAMP_REST;
  assign k[3] = r_key[127:96] & p1305_pkg::CLAMP_REST;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f[i] = {3'b0, k[i][27:2]} + {1'b0, k[i][27:2], 2'b00};
    end
    d = 2'(n_r - m_r);
    if (n_r == 3'd4) begin
      coef = (m_r == 3'd4) ? {27'b0, k[0][1:0]} : '0;
    end else if (m_r <= n_r) begin
      coef = k[d][28:0];
    end else begin
      coef = f[d];
    end
  end

  assign last_issue = (n_r == 3'd4) && (m_r == 3'd4);

  always_comb begin
    top  = p_r[4] + {32'b0, p_r[3][63:32]};
    base = (k_r == 3'd0) ? ({2'b0, top[63:2]} + {top[63:2], 2'b00}) : carry_r;
    ta   = '0;
    tb   = '0;
    case (k_r)
      3'd0: ta = {32'b0, p_r[0][31:0]};
      3'd1: begin ta = {32'b0, p_r[1][31:0]}; tb = {32'b0, p_r[0][63:32]}; end
      3'd2: begin ta = {32'b0, p_r[2][31:0]}; tb = {32'b0, p_r[1][63:32]}; end
      3'd3: begin ta = {32'b0, p_r[3][31:0]}; tb = {32'b0, p_r[2][63:32]}; end
      default: ta = {62'b0, top[1:0]};
    endcase
    sum = base + ta + tb;
  end

  assign h   = {acc_r[4], acc_r[3], acc_r[2], acc_r[1], acc_r[0]};
  assign hd  = h + p1305_pkg::NEG_P;
  assign tag = h[127:0] + pad;

  assign out_free  = !out_valid_r || out_ready;
  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = job_data.fold ? ST_MUL : ST_REDUCE;
        end
      end
      ST_MUL:    if (last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_CARRY;
      ST_CARRY:  if (k_r == 3'd4) state_nxt = fin_r ? ST_REDUCE : ST_IDLE;
      ST_REDUCE: state_nxt = ST_PAD;
      ST_PAD:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(a_r[m_r] * coef);
    pn_r   <= n_r;
    if (state_r == ST_IDLE && job_valid) begin
      for (int i = 0; i < 4; i++) begin
        a_r[i] <= {1'b0, acc_r[i]} + {1'b0, job_data.words[32*i +: 32]};
      end
      a_r[4] <= {1'b0, acc_r[4]} + {32'b0, job_data.hibit};
      fin_r  <= job_data.fin;
      for (int i = 0; i < 5; i++) begin
        p_r[i] <= '0;
      end
    end else if (pv_r) begin
      p_r[pn_r] <= p_r[pn_r] + prod_r;
    end
    if (state_r == ST_CARRY) begin
      carry_r <= {32'b0, sum[63:32]};
    end
    if (state_r == ST_PAD && out_free) begin
      out_data_r.tag_low  <= tag[63:0];
      out_data_r.tag_high <= tag[127:64];
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      n_r         <= '0;
      m_r         <= '0;
      k_r         <= '0;
      for (int i = 0; i < 5; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == ST_MUL);
      if (state_r == ST_MUL) begin
        if (m_r == 3'd4) begin
          m_r <= '0;
          n_r <= last_issue ? '0 : n_r + 1'b1;
        end else begin
          m_r <= m_r + 1'b1;
        end
      end
      if (state_r == ST_CARRY) begin
        acc_r[k_r] <= sum[31:0];
        k_r <= (k_r == 3'd4) ? '0 : k_r + 1'b1;
      end
      if (state_r == ST_REDUCE && !hd[159]) begin
        for (int i = 0; i < 5; i++) begin
          acc_r[i] <= hd[32*i +: 32];
        end
      end
      if (state_r == ST_PAD && out_free) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 5; i++) begin
          acc_r[i] <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `P1305_ASSERT(a_pop_idle, job_valid && job_ready, state_r == ST_IDLE)
  `P1305_ASSERT(a_pad_fin, state_r == ST_PAD || state_r == ST_REDUCE, fin_r)
  `P1305_ASSERT_NEXT(a_mul_drain, state_r == ST_MUL && last_issue, state_r == ST_DRAIN && pv_r)
endmodule

// ===== hdl/poly1305_mac_engine_unit.sv =====
// Poly1305 authenticator: one message byte or finish command per input beat,
// one 128-bit tag per finish. Bytes are taken one a cycle while the job queue
// has room; a full sixteen-byte block is queued when the next byte or a finish
// arrives, and each finish queues a job. The block engine works a block as 25
// products through one 33x29 multiplier, a drain and five carry steps, and a
// finish adds the final reduction and pad add. The engine takes a new job only
// when idle; the queue depth sets how far the byte packer can run ahead. Key
// registers are written through the cfg port; the user must write them only
// while idle, as the block itself does not enforce this. Depends on p1305_pkg
// and the other p1305_* modules.
module poly1305_mac_engine_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  p1305_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output p1305_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_wdata
);
  logic [63:0] r_low_r, r_high_r, pad_low_r, pad_high_r;
  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  p1305_pkg::job_t q_in_data, q_out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r    <= '0;
      r_high_r   <= '0;
      pad_low_r  <= '0;
      pad_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        p1305_pkg::CFG_R_LOW:    r_low_r    <= cfg_wdata;
        p1305_pkg::CFG_R_HIGH:   r_high_r   <= cfg_wdata;
        p1305_pkg::CFG_PAD_LOW:  pad_low_r  <= cfg_wdata;
        p1305_pkg::CFG_PAD_HIGH: pad_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  p1305_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (q_in_valid),
    .job_ready (q_in_ready),
    .job_data  (q_in_data)
  );

  p1305_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  p1305_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_out_valid),
    .job_ready (q_out_ready),
    .job_data  (q_out_data),
    .r_key     ({r_high_r, r_low_r}),
    .pad       ({pad_high_r, pad_low_r}),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// ===== tb/sv/tb_poly1305_mac_engine_unit.sv =====
// Self-checking testbench for poly1305_mac_engine_unit: byte streams and finish beats
// go in, and tags are checked against a wide-integer Poly1305 predictor.
// Depends on p1305_pkg and the engine RTL.
module tb_poly1305_mac_engine_unit;

  localparam logic [263:0] PRIME      = (264'd1 << 130) - 264'd5;
  localparam logic [127:0] CLAMP_MASK = {p1305_pkg::CLAMP_REST, p1305_pkg::CLAMP_REST,
                                         p1305_pkg::CLAMP_REST, p1305_pkg::CLAMP_LOW};
  localparam int           CYCLE_LIMIT = 600000;
  localparam int           SETTLE      = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  p1305_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  p1305_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [63:0]          cfg_wdata;

  p1305_pkg::in_item_t  pending_beats[$];
  p1305_pkg::out_item_t tag_queue[$];
  int          errors;
  int          cycles;
  int          in_gap;
  int          out_gap;
  bit          in_fire;
  bit          out_fire;
  bit          in_calm;
  bit          out_calm;

  logic [63:0]  key_r_low, key_r_high, key_pad_low, key_pad_high;
  logic [263:0] acc_h;
  logic [127:0] block_buf;
  int           block_fill;

  poly1305_mac_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic void fold_block(input bit hibit);
    logic [263:0] r;
    logic [263:0] sum;
    r = {136'd0, {key_r_high, key_r_low} & CLAMP_MASK};
    sum = acc_h + {136'd0, block_buf} + ({263'd0, hibit} << 128);
    acc_h = (sum * r) % PRIME;
  endfunction

  function automatic void mac_beat(input p1305_pkg::in_item_t beat);
    logic [263:0]         tag;
    p1305_pkg::out_item_t res;
    if (beat.kind == p1305_pkg::KIND_BYTE) begin
      if (block_fill == 16) begin
        fold_block(1'b1);
        block_buf = '0;
        block_fill = 0;
      end
      block_buf[block_fill*8 +: 8] = beat.data_byte;
      block_fill++;
    end else begin
      if (block_fill == 16) begin
        fold_block(1'b1);
      end else if (block_fill != 0) begin
        block_buf[block_fill*8 +: 8] = 8'h01;
        fold_block(1'b0);
      end
      tag = acc_h + {136'd0, key_pad_high, key_pad_low};
      res.tag_low  = tag[63:0];
      res.tag_high = tag[127:64];
      tag_queue.push_back(res);
      acc_h = '0;
      block_buf = '0;
      block_fill = 0;
    end
  endfunction

  always @(posedge clk) begin
    in_fire  = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    if (rst_n) begin
      cycles++;
      if (cfg_we) begin
        case (cfg_index)
          p1305_pkg::CFG_R_LOW:    key_r_low    = cfg_wdata;
          p1305_pkg::CFG_R_HIGH:   key_r_high   = cfg_wdata;
          p1305_pkg::CFG_PAD_LOW:  key_pad_low  = cfg_wdata;
          p1305_pkg::CFG_PAD_HIGH: key_pad_high = cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) mac_beat(in_data);
      if (out_fire) begin
        if (tag_queue.size() == 0) begin
          report("unexpected tag", out_data.tag_low, 64'd0);
        end else begin
          if (out_data.tag_low !== tag_queue[0].tag_low)
            report("tag_low", out_data.tag_low, tag_queue[0].tag_low);
          if (out_data.tag_high !== tag_queue[0].tag_high)
            report("tag_high", out_data.tag_high, tag_queue[0].tag_high);
          void'(tag_queue.pop_front());
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("poly1305_mac_engine_unit regression: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    logic                nxt_valid;
    p1305_pkg::in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n && (!in_valid || in_fire)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_beats.size() != 0) begin
        nxt_data  = pending_beats.pop_front();
        nxt_valid = 1'b1;
        if ($urandom_range(0, 40) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 14);
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = out_ready;
    if (rst_n) begin
      if (out_fire || !out_ready) begin
        if (out_gap > 0) begin
          out_gap--;
          nxt_ready = 1'b0;
        end else begin
          nxt_ready = 1'b1;
          if ($urandom_range(0, 6) == 0) out_calm = !out_calm;
          out_gap = out_calm ? 0 : $urandom_range(0, 14);
        end
      end
    end
    out_ready <= nxt_ready;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                          input logic [63:0] pl, input logic [63:0] ph);
    write_reg(p1305_pkg::CFG_R_LOW, rl);
    write_reg(p1305_pkg::CFG_R_HIGH, rh);
    write_reg(p1305_pkg::CFG_PAD_LOW, pl);
    write_reg(p1305_pkg::CFG_PAD_HIGH, ph);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_bytes(input int len, input int fill);
    p1305_pkg::in_item_t b;
    for (int i = 0; i < len; i++) begin
      b.kind = p1305_pkg::KIND_BYTE;
      case (fill)
        0:       b.data_byte = 8'h00;
        1:       b.data_byte = 8'hff;
        default: b.data_byte = 8'($urandom_range(0, 255));
      endcase
      pending_beats.push_back(b);
    end
  endtask

  task automatic push_finish();
    p1305_pkg::in_item_t b;
    b.kind = p1305_pkg::KIND_FINISH;
    b.data_byte = 8'($urandom_range(0, 255));
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid);
    wait (tag_queue.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    errors = 0;
    cycles = 0;
    in_gap = 0;
    out_gap = 0;
    in_calm = 0;
    out_calm = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = p1305_pkg::CFG_R_LOW;
    cfg_wdata = '0;
    key_r_low = '0; key_r_high = '0; key_pad_low = '0; key_pad_high = '0;
    acc_h = '0; block_buf = '0; block_fill = 0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    load_key('1, '1, '1, '1);
    push_finish();
    push_bytes(1, 1); push_finish();
    push_bytes(15, 1); push_finish();
    push_bytes(16, 1); push_finish();
    push_bytes(17, 0); push_finish();
    push_bytes(32, 1); push_finish();
    drain();
    load_key('0, '0, '0, '0);
    push_bytes(16, 2); push_finish();
    push_finish();
    drain();

    sent = 0;
    while (sent < 1700) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 40);
        push_bytes(len, $urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) begin
          drain();
          load_key(rand64(), rand64(), rand64(), rand64());
          push_bytes($urandom_range(0, 20), 2);
        end
        push_finish();
        sent += len + 1;
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("poly1305_mac_engine_unit regression: pass");
    end else begin
      $display("poly1305_mac_engine_unit regression: fail");
    end
    $finish;
  end
endmodule
